### rtl/core/hsi_fire_pixel_classifier_assert.svh
// ----------------------------------------------------------------------------
// HSI fire pixel classifier assertion macros
// Concurrent assertion forms for the classifier checker.
// ----------------------------------------------------------------------------
`ifndef HSI_FIRE_PIXEL_CLASSIFIER_ASSERT_SVH
`define HSI_FIRE_PIXEL_CLASSIFIER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HFPC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hfpc: implication failed");

// antecedent implies the signal holds into the next cycle
`define HFPC_ASSERT_HOLD(lbl, ante, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> $stable(sig)) \
    else $error("hfpc: value did not hold");

`endif

### rtl/core/hfpc_pkg.sv
// ----------------------------------------------------------------------------
// HSI fire pixel classifier package
// Payload types, register indexes and the cosine tables for the hue search.
// ----------------------------------------------------------------------------
package hfpc_pkg;

  localparam int unsigned CosW   = 22;
  localparam int unsigned CosSqW = 41;
  localparam int unsigned HueSpan = 180;

  // (2n-1)(2n) for the Taylor terms of the cosine series
  localparam longint unsigned TaylorDiv [1:14] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
    64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [8:0] hue_deg;
    logic [7:0] saturation;
    logic [7:0] intensity;
    logic       fire;
  } pix_out_t;

  typedef enum logic [2:0] {
    REG_HUE_LOW  = 3'd0,
    REG_HUE_HIGH = 3'd1,
    REG_SAT_LOW  = 3'd2,
    REG_SAT_HIGH = 3'd3,
    REG_INT_LOW  = 3'd4,
    REG_INT_HIGH = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]         hue_pos;
    logic               mirror;
    logic signed [10:0] x;
    logic [15:0]        dd;
    logic [9:0]         rem;
    logic [7:0]         nlo;
    logic [9:0]         den;
    logic [7:0]         quo;
    logic [7:0]         inten;
  } pipe_t;

  typedef logic signed [CosW-1:0] cos_tab_t [0:HueSpan];
  typedef logic [CosSqW-1:0] cos_sq_tab_t [0:HueSpan];

  function automatic cos_tab_t build_cos();
    cos_tab_t         t;
    longint unsigned  pi_q30;
    longint unsigned  a;
    longint unsigned  term;
    longint unsigned  q;
    longint           acc;
    pi_q30 = (64'd314159265 << 30) / 64'd100000000;
    for (int d = 0; d <= 90; d++) begin
      a    = (longint'(d) * pi_q30) / 64'd180;
      term = 64'd1 << 30;
      acc  = longint'(term);
      for (int n = 1; n <= 14; n++) begin
        term = (term * a) >> 30;
        term = (term * a) >> 30;
        term = term / TaylorDiv[n];
        if ((n % 2) == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      q = (longint'(acc) + 64'd512) >> 10;
      t[d] = CosW'(q);
      if (d < 90) t[HueSpan - d] = -CosW'(q);
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos();

  function automatic cos_sq_tab_t build_cos_sq();
    cos_sq_tab_t t;
    longint      v;
    for (int d = 0; d <= HueSpan; d++) begin
      v = longint'(COS_TAB[d]);
      t[d] = CosSqW'(v * v);
    end
    return t;
  endfunction

  localparam cos_sq_tab_t COS_SQ = build_cos_sq();

endpackage

### rtl/core/hsi_fire_pixel_classifier.sv
// ----------------------------------------------------------------------------
// HSI fire pixel classifier
// RGB pixel to hue, saturation, intensity with a fire flag on bounds.
// ----------------------------------------------------------------------------
//  channel  | ports                         | moves
//  in       | in_valid, in_stall, in_data   | one RGB pixel per transfer
//  out      | out_valid, out_stall, out_data| hue, saturation, intensity, fire
//  cfg      | cfg_we, cfg_index, cfg_wdata  | bound register writes
//
// One pixel per cycle while the output does not stall; stages: front stage, eight cells, output.
// Each cell settles one hue bisection bit and one quotient bit.
// Synchronous active-low reset clears valids and sets bound defaults.
// A stalled stage holds; empty stages fill while the output waits.
// ----------------------------------------------------------------------------
module hsi_fire_pixel_classifier (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hfpc_pkg::pix_in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hfpc_pkg::pix_out_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [8:0]         cfg_wdata
);

  localparam int unsigned NumCells = 8;

  logic [8:0] hue_low_r;
  logic [8:0] hue_high_r;
  logic [7:0] sat_low_r;
  logic [7:0] sat_high_r;
  logic [7:0] int_low_r;
  logic [7:0] int_high_r;

  logic            front_rdy;
  logic            st_valid [0:NumCells];
  hfpc_pkg::pipe_t st_data  [0:NumCells];
  logic            st_rdy   [0:NumCells];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r  <= 9'd0;
      hue_high_r <= 9'd60;
      sat_low_r  <= 8'd20;
      sat_high_r <= 8'd255;
      int_low_r  <= 8'd30;
      int_high_r <= 8'd255;
    end else if (cfg_we) begin
      unique case (hfpc_pkg::cfg_reg_t'(cfg_index))
        hfpc_pkg::REG_HUE_LOW:  hue_low_r  <= cfg_wdata;
        hfpc_pkg::REG_HUE_HIGH: hue_high_r <= cfg_wdata;
        hfpc_pkg::REG_SAT_LOW:  sat_low_r  <= cfg_wdata[7:0];
        hfpc_pkg::REG_SAT_HIGH: sat_high_r <= cfg_wdata[7:0];
        hfpc_pkg::REG_INT_LOW:  int_low_r  <= cfg_wdata[7:0];
        hfpc_pkg::REG_INT_HIGH: int_high_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall = !front_rdy;

  hfpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_data  (in_data),
    .up_rdy   (front_rdy),
    .dn_valid (st_valid[0]),
    .dn_data  (st_data[0]),
    .dn_rdy   (st_rdy[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    hfpc_cell #(
      .BIT (NumCells - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[i]),
      .up_data  (st_data[i]),
      .up_rdy   (st_rdy[i]),
      .dn_valid (st_valid[i+1]),
      .dn_data  (st_data[i+1]),
      .dn_rdy   (st_rdy[i+1])
    );
  end

  hfpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (st_valid[NumCells]),
    .up_data   (st_data[NumCells]),
    .up_rdy    (st_rdy[NumCells]),
    .hue_low   (hue_low_r),
    .hue_high  (hue_high_r),
    .sat_low   (sat_low_r),
    .sat_high  (sat_high_r),
    .int_low   (int_low_r),
    .int_high  (int_high_r),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

### rtl/core/hfpc_front.sv
// ----------------------------------------------------------------------------
// HSI fire pixel classifier front stage
// Forms sum, intensity, divider operands and the hue discriminant terms.
// ----------------------------------------------------------------------------
module hfpc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  hfpc_pkg::pix_in_t up_data,
  output logic              up_rdy,
  output logic              dn_valid,
  output hfpc_pkg::pipe_t   dn_data,
  input  logic              dn_rdy
);

  logic            v_r;
  hfpc_pkg::pipe_t data_r;
  hfpc_pkg::pipe_t data_nxt;

  logic [9:0]  sum;
  logic [7:0]  mn;
  logic [9:0]  spread;
  logic [17:0] numer;
  logic [19:0] inten_p;
  logic [17:0] sq_sum;
  logic [17:0] cross_sum;
  logic [17:0] dd_full;

  always_comb begin
    sum = 10'(up_data.red) + 10'(up_data.green) + 10'(up_data.blue);
    mn = up_data.red;
    if (up_data.green < mn) mn = up_data.green;
    if (up_data.blue < mn) mn = up_data.blue;
    spread = sum - 10'(3 * mn);
    numer = (18'(spread) << 8) - 18'(spread);
    inten_p = 20'(sum) * 20'd683;
    sq_sum = 18'(up_data.red * up_data.red) + 18'(up_data.green * up_data.green)
           + 18'(up_data.blue * up_data.blue);
    cross_sum = 18'(up_data.red * up_data.green) + 18'(up_data.red * up_data.blue)
              + 18'(up_data.green * up_data.blue);
    dd_full = sq_sum - cross_sum;

    data_nxt.hue_pos = '0;
    data_nxt.mirror  = up_data.green < up_data.blue;
    data_nxt.x       = 11'(signed'({3'b000, up_data.red} << 1))
                     - 11'(signed'({3'b000, up_data.green}))
                     - 11'(signed'({3'b000, up_data.blue}));
    data_nxt.dd      = dd_full[15:0];
    data_nxt.rem     = numer[17:8];
    data_nxt.nlo     = numer[7:0];
    data_nxt.den     = (sum == 10'd0) ? 10'd1 : sum;
    data_nxt.quo     = '0;
    data_nxt.inten   = inten_p[18:11];
  end

  assign up_rdy   = !v_r || dn_rdy;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_rdy) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/core/hfpc_cell.sv
// ----------------------------------------------------------------------------
// HSI fire pixel classifier cell
// One bisection step of the hue search and one quotient bit of saturation.
// ----------------------------------------------------------------------------
module hfpc_cell #(
  parameter int unsigned BIT = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  input  hfpc_pkg::pipe_t up_data,
  output logic            up_rdy,
  output logic            dn_valid,
  output hfpc_pkg::pipe_t dn_data,
  input  logic            dn_rdy
);

  logic            v_r;
  hfpc_pkg::pipe_t data_r;
  hfpc_pkg::pipe_t data_nxt;

  logic [8:0]                     cand;
  logic [8:0]                     test_idx;
  logic                           in_range;
  logic [7:0]                     idx;
  logic signed [hfpc_pkg::CosW-1:0] c;
  logic [9:0]                     xm;
  logic [57:0]                    lhs;
  logic [57:0]                    rhs;
  logic                           gt;
  logic                           lt;
  logic                           eq;
  logic                           take;
  logic [10:0]                    rem2;
  logic                           ge;

  always_comb begin
    cand     = {1'b0, up_data.hue_pos} + 9'(2 ** BIT);
    in_range = cand <= 9'(hfpc_pkg::HueSpan);
    test_idx = up_data.mirror ? cand - 9'd1 : cand;
    idx      = in_range ? test_idx[7:0] : 8'd0;
    c        = hfpc_pkg::COS_TAB[idx];
    xm       = up_data.x[10] ? 10'(-up_data.x) : 10'(up_data.x);
    lhs      = 58'(20'(xm) * 20'(xm)) << 38;
    rhs      = 58'(hfpc_pkg::COS_SQ[idx] * 57'(up_data.dd));
    gt = 1'b0;
    lt = 1'b0;
    eq = 1'b0;
    priority if (!up_data.x[10] && (c <= 0)) begin
      eq = (up_data.x == 0) && (c == 0);
      gt = !eq;
    end else if (up_data.x <= 0 && c >= 0) begin
      lt = 1'b1;
    end else if (lhs == rhs) begin
      eq = 1'b1;
    end else if (!up_data.x[10]) begin
      gt = lhs > rhs;
      lt = !(lhs > rhs);
    end else begin
      lt = lhs > rhs;
      gt = !(lhs > rhs);
    end
    take = in_range && (up_data.mirror ? lt : !gt);

    rem2 = {up_data.rem, up_data.nlo[7]};
    ge   = rem2 >= {1'b0, up_data.den};

    data_nxt         = up_data;
    data_nxt.hue_pos = take ? cand[7:0] : up_data.hue_pos;
    data_nxt.rem     = ge ? 10'(rem2 - {1'b0, up_data.den}) : rem2[9:0];
    data_nxt.nlo     = {up_data.nlo[6:0], 1'b0};
    data_nxt.quo     = {up_data.quo[6:0], ge};
  end

  assign up_rdy   = !v_r || dn_rdy;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_rdy) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/core/hfpc_back.sv
// ----------------------------------------------------------------------------
// HSI fire pixel classifier output stage
// Mirrors the hue, applies the bounds and holds the result for transfer.
// ----------------------------------------------------------------------------
module hfpc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  hfpc_pkg::pipe_t    up_data,
  output logic               up_rdy,
  input  logic [8:0]         hue_low,
  input  logic [8:0]         hue_high,
  input  logic [7:0]         sat_low,
  input  logic [7:0]         sat_high,
  input  logic [7:0]         int_low,
  input  logic [7:0]         int_high,
  output logic               out_valid,
  output hfpc_pkg::pix_out_t out_data,
  input  logic               out_stall
);

  logic               v_r;
  hfpc_pkg::pix_out_t data_r;
  hfpc_pkg::pix_out_t data_nxt;
  logic [8:0]         hue;

  always_comb begin
    priority if (up_data.dd == 16'd0) begin
      hue = 9'd0;
    end else if (!up_data.mirror) begin
      hue = {1'b0, up_data.hue_pos};
    end else if (up_data.hue_pos == 8'd0) begin
      hue = 9'd359;
    end else begin
      hue = 9'd360 - {1'b0, up_data.hue_pos};
    end
    data_nxt.hue_deg    = hue;
    data_nxt.saturation = up_data.quo;
    data_nxt.intensity  = up_data.inten;
    data_nxt.fire       = (hue > hue_low) && (hue < hue_high)
                       && (up_data.quo > sat_low) && (up_data.quo < sat_high)
                       && (up_data.inten > int_low) && (up_data.inten < int_high);
  end

  assign up_rdy    = !v_r || !out_stall;
  assign out_valid = v_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_rdy) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/core/hfpc_checker.sv
// ----------------------------------------------------------------------------
// HSI fire pixel classifier checker
// Port-level assertions on result transfers, bound to the top level.
// ----------------------------------------------------------------------------
`include "hsi_fire_pixel_classifier_assert.svh"

module hfpc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input hfpc_pkg::pix_out_t out_data
);

  `HFPC_ASSERT_HOLD(a_out_valid_hold, out_valid && out_stall, out_valid)
  `HFPC_ASSERT_HOLD(a_out_data_hold, out_valid && out_stall, out_data)
  `HFPC_ASSERT_IMPL(a_hue_range, out_valid, out_data.hue_deg <= 9'd359)
  `HFPC_ASSERT_IMPL(a_fire_nonzero, out_valid && out_data.fire, out_data.saturation != 8'd0 && out_data.intensity != 8'd0)

endmodule

bind hsi_fire_pixel_classifier hfpc_checker u_hfpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/hsi_fire_pixel_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSI fire pixel classifier testbench
// Drives RGB pixels in bursts with random gaps against a randomly stalling
// receiver and checks hue, saturation, intensity and the fire flag of every
// result against an independent fixed-point predictor. The run covers
// directed corner pixels, then random phases under several bound settings.
// ----------------------------------------------------------------------------
module hsi_fire_pixel_classifier_tb;

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_PIXELS = 185;

  class pixel_scoreboard;
    longint cos_q20 [0:180];
    int unsigned bound [0:5];
    hfpc_pkg::pix_out_t pending_q [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned fire_seen;

    function new();
      longint unsigned pi_q30, a, term;
      longint acc, q;
      pi_q30 = (64'd314159265 << 30) / 64'd100000000;
      for (int d = 0; d <= 90; d++) begin
        a = (longint'(d) * pi_q30) / 64'd180;
        term = 64'd1 << 30;
        acc = longint'(term);
        for (int n = 1; n <= 14; n++) begin
          term = (term * a) >> 30;
          term = (term * a) >> 30;
          term = term / longint'((2 * n - 1) * (2 * n));
          if (n % 2 == 1) acc -= longint'(term);
          else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        q = (acc + 512) >>> 10;
        cos_q20[d] = q;
        if (d < 90) cos_q20[180 - d] = -q;
      end
      bound = '{0, 60, 20, 255, 30, 255};
      errors = 0;
      checked = 0;
      fire_seen = 0;
    endfunction

    function void set_bound(logic [2:0] idx, logic [8:0] val);
      case (idx)
        hfpc_pkg::REG_HUE_LOW, hfpc_pkg::REG_HUE_HIGH: bound[idx] = val;
        hfpc_pkg::REG_SAT_LOW, hfpc_pkg::REG_SAT_HIGH,
        hfpc_pkg::REG_INT_LOW, hfpc_pkg::REG_INT_HIGH: bound[idx] = val[7:0];
        default: ;
      endcase
    endfunction

    // sign of x/(2*sqrt(dd)) - c/2^20
    function int cos_sign(longint x, longint dd, longint c);
      longint p;
      longint unsigned pm, cm, lhs, rhs;
      p = x * 524288;
      if (p >= 0 && c <= 0) return (p == 0 && c == 0) ? 0 : 1;
      if (p <= 0 && c >= 0) return -1;
      pm = (p < 0) ? -p : p;
      cm = (c < 0) ? -c : c;
      lhs = pm * pm;
      rhs = cm * cm * longint'(dd);
      if (lhs == rhs) return 0;
      if (p > 0) return (lhs > rhs) ? 1 : -1;
      return (lhs > rhs) ? -1 : 1;
    endfunction

    function hfpc_pkg::pix_out_t classify(hfpc_pkg::pix_in_t px);
      hfpc_pkg::pix_out_t res;
      longint r, g, b, mn, sum, x, dd, hue, sat, inten;
      int d;
      r = px.red;
      g = px.green;
      b = px.blue;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      sum = r + g + b;
      inten = sum / 3;
      sat = (sum > 0) ? (255 * (sum - 3 * mn)) / sum : 0;
      x = 2 * r - g - b;
      dd = r * r + g * g + b * b - r * g - r * b - g * b;
      hue = 0;
      if (dd > 0) begin
        if (g >= b) begin
          d = 180;
          while (d > 0 && cos_sign(x, dd, cos_q20[d]) > 0) d--;
          hue = d;
        end else begin
          d = 0;
          while (d < 180 && cos_sign(x, dd, cos_q20[d]) < 0) d++;
          hue = 360 - d;
          if (hue > 359) hue = 359;
        end
      end
      res.hue_deg = hue[8:0];
      res.saturation = sat[7:0];
      res.intensity = inten[7:0];
      res.fire = (hue > bound[hfpc_pkg::REG_HUE_LOW] && hue < bound[hfpc_pkg::REG_HUE_HIGH] &&
                  sat > bound[hfpc_pkg::REG_SAT_LOW] && sat < bound[hfpc_pkg::REG_SAT_HIGH] &&
                  inten > bound[hfpc_pkg::REG_INT_LOW] &&
                  inten < bound[hfpc_pkg::REG_INT_HIGH]);
      return res;
    endfunction

    function void note(hfpc_pkg::pix_in_t px);
      pending_q.push_back(classify(px));
    endfunction

    function void check(hfpc_pkg::pix_out_t got);
      hfpc_pkg::pix_out_t exp_res;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer: %p", got);
        errors++;
        return;
      end
      exp_res = pending_q.pop_front();
      checked++;
      if (exp_res.fire) fire_seen++;
      if (got.hue_deg !== exp_res.hue_deg) begin
        $error("hue_deg: expected %0d, got %0d", exp_res.hue_deg, got.hue_deg);
        errors++;
      end
      if (got.saturation !== exp_res.saturation) begin
        $error("saturation: expected %0d, got %0d", exp_res.saturation, got.saturation);
        errors++;
      end
      if (got.intensity !== exp_res.intensity) begin
        $error("intensity: expected %0d, got %0d", exp_res.intensity, got.intensity);
        errors++;
      end
      if (got.fire !== exp_res.fire) begin
        $error("fire: expected %0b, got %0b", exp_res.fire, got.fire);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  hfpc_pkg::pix_in_t in_data;
  logic out_valid;
  logic out_stall;
  hfpc_pkg::pix_out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [8:0] cfg_wdata;

  pixel_scoreboard sb;
  int unsigned idle_cycles;
  int unsigned stall_pct;
  int unsigned stall_window;

  hsi_fire_pixel_classifier DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver stall pattern: windows of varying stall density, some without stalls
  always @(negedge clk) begin
    if (stall_window == 0) begin
      stall_window = $urandom_range(300, 20);
      case ($urandom_range(4))
        0, 1: stall_pct = 0;
        2: stall_pct = 25;
        3: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    stall_window--;
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("hsi_fire_pixel_classifier test failed");
      $finish;
    end
  end

  task automatic send_pixel(hfpc_pkg::pix_in_t px);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
    sb.note(px);
  endtask

  task automatic idle_sender(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain();
    idle_sender(1);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [8:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_bound(idx, val);
  endtask

  task automatic write_bounds(logic [8:0] hl, logic [8:0] hh, logic [8:0] sl,
                              logic [8:0] sh, logic [8:0] il, logic [8:0] ih);
    write_reg(hfpc_pkg::REG_HUE_LOW, hl);
    write_reg(hfpc_pkg::REG_HUE_HIGH, hh);
    write_reg(hfpc_pkg::REG_SAT_LOW, sl);
    write_reg(hfpc_pkg::REG_SAT_HIGH, sh);
    write_reg(hfpc_pkg::REG_INT_LOW, il);
    write_reg(hfpc_pkg::REG_INT_HIGH, ih);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] corner_val();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      default: return 8'd254;
    endcase
  endfunction

  function automatic hfpc_pkg::pix_in_t random_pixel();
    hfpc_pkg::pix_in_t px;
    logic [7:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: px = hfpc_pkg::pix_in_t'($urandom());
      4, 5, 6: begin
        px.red = $urandom_range(255, 120);
        px.green = $urandom_range(px.red, 0);
        px.blue = $urandom_range(px.green, 0);
      end
      7: begin
        v = $urandom();
        px = '{v, v, v};
      end
      8: px = '{corner_val(), corner_val(), corner_val()};
      default: begin
        px = hfpc_pkg::pix_in_t'($urandom());
        if (px.green >= px.blue) px.blue = $urandom_range(255, px.green + 1 > 255 ? 255 : px.green + 1);
      end
    endcase
    return px;
  endfunction

  initial begin
    hfpc_pkg::pix_in_t corner_px [$];
    int unsigned left;
    sb = new();
    stall_window = 0;
    stall_pct = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = hfpc_pkg::REG_HUE_LOW;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset bounds, corner pixels
    corner_px = '{'{0, 0, 0}, '{255, 255, 255}, '{128, 128, 128}, '{1, 1, 1},
                  '{255, 0, 0}, '{0, 255, 0}, '{0, 0, 255}, '{255, 255, 0},
                  '{0, 255, 255}, '{255, 0, 255}, '{255, 0, 1}, '{255, 1, 0},
                  '{1, 0, 0}, '{0, 0, 1}, '{255, 254, 0}, '{0, 254, 255},
                  '{255, 128, 0}, '{200, 60, 10}, '{10, 200, 250}, '{254, 255, 255},
                  '{255, 170, 85}, '{0, 1, 1}};
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    drain();

    // open bounds, out-of-range hue bound, unused indexes and the stray ninth bit
    write_bounds(9'd0, 9'd511, 9'h100, 9'h1ff, 9'h100, 9'h1ff);
    write_reg(REG_SPARE_A, 9'h1ff);
    write_reg(REG_SPARE_B, 9'h0);
    @(negedge clk);
    cfg_we <= 1'b0;
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: write_bounds(9'd0, 9'd60, 9'd20, 9'd255, 9'd30, 9'd255);
        1: write_bounds(9'd511, 9'd511, 9'd255, 9'd255, 9'd255, 9'd255);
        2: write_bounds(9'd0, 9'd360, 9'd0, 9'd255, 9'd0, 9'd255);
        3: write_bounds(9'd359, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
        default: write_bounds($urandom_range(90), $urandom_range(360, 30),
                              $urandom_range(80), $urandom_range(255, 100),
                              $urandom_range(100), $urandom_range(255, 120));
      endcase
      left = PHASE_PIXELS;
      while (left > 0) begin
        for (int unsigned k = $urandom_range(40, 1); k > 0 && left > 0; k--) begin
          send_pixel(random_pixel());
          left--;
        end
        if ($urandom_range(3) != 0) idle_sender($urandom_range(12, 1));
      end
      drain();
    end

    $display("checked %0d results (%0d with fire set) over %0d bound settings",
             sb.checked, sb.fire_seen, RANDOM_PHASES + 2);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("hsi_fire_pixel_classifier test passed");
    end else begin
      $display("hsi_fire_pixel_classifier test failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/hfpc_pkg.sv
rtl/core/hfpc_front.sv
rtl/core/hfpc_cell.sv
rtl/core/hfpc_back.sv
rtl/core/hsi_fire_pixel_classifier.sv
rtl/core/hfpc_checker.sv
tb/hsi_fire_pixel_classifier_tb.sv
